FILE: hw/rtl/distance_vector_route_table_core_macros.svh
// Assertion macros for the route table checker
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_CORE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_CORE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define DVRT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dvrt: check failed");

// next-cycle implication
`define DVRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dvrt: check failed");

`endif

FILE: hw/rtl/dvrt_pkg.sv
// Shared types, widths and status codes of the route table
package dvrt_pkg;

    localparam int NET_W        = 16;
    localparam int ID_W         = 5;
    localparam int DIST_W       = 5;
    localparam int COST_W       = 4;
    localparam int MASK_W       = 32;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam int TABLE_ENTRIES_DEF = 24;
    localparam int ROUTER_IDS        = 32;

    localparam logic [DIST_W-1:0] UNREACHABLE = DIST_W'(16);
    localparam logic [COST_W-1:0] COST_RST    = COST_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_COST     = 1'b1;

    localparam logic [STATUS_W-1:0] ST_UPDATED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_NEIGHBOR = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd5;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic [NET_W-1:0]  net;
        logic [ID_W-1:0]   hop;
        logic [DIST_W-1:0] metric;
    } t_entry;

endpackage

FILE: hw/rtl/dvrt_ram.sv
// Generic single-write, single-read RAM with registered read data
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/distance_vector_route_table_core.sv
// Route table core: holds the routes, takes updates and answers best-route queries
// One item at a time. After start is taken, busy stays high while a single
// comparator walks the table one entry per cycle through the table RAM's
// read port. The steps are the first read, one compare per entry, and a
// finish step that writes back and registers the result; o_strobe rises with
// the result on o_status/o_next_hop at the same edge as busy drops. An update
// from a non-neighbour or for network zero, and a query for network zero,
// skip the walk and go straight to the finish step. The result cannot be held
// off, so a user must sample it in its strobe cycle. The table is empty
// straight after reset (per-entry valid bits); the user must write neighbour
// mask and link cost via i_cfg_* only while the block is idle, and the block
// itself does not enforce it.
module distance_vector_route_table_core #(
    parameter int TABLE_ENTRIES = dvrt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic [dvrt_pkg::ID_W-1:0]         i_sender_id,
    input  logic [dvrt_pkg::NET_W-1:0]        i_dest_network,
    input  logic [dvrt_pkg::DIST_W-1:0]       i_advertised_distance,
    output logic                              o_strobe,
    output logic [dvrt_pkg::STATUS_W-1:0]     o_status,
    output logic [dvrt_pkg::ID_W-1:0]         o_next_hop,
    input  logic                              i_cfg_we,
    input  logic [dvrt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dvrt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import dvrt_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]              r_state;
    logic [MASK_W-1:0]       r_mask;
    logic [COST_W-1:0]       r_cost;
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic                    r_mode;
    logic [ID_W-1:0]         r_sender;
    logic [NET_W-1:0]        r_net;
    logic [DIST_W-1:0]       r_sum;
    logic                    r_nbr;

    logic [IW-1:0]           r_addr;
    logic                    r_issue_done;
    logic                    r_cmp_vld;
    logic [IW-1:0]           r_cmp_idx;

    logic                    r_hit;
    logic [IW-1:0]           r_hit_idx;
    logic [DIST_W-1:0]       r_best;
    logic [ID_W-1:0]         r_best_hop;
    logic                    r_free;
    logic [IW-1:0]           r_free_idx;

    logic                    r_strobe;
    logic [STATUS_W-1:0]     r_status;
    logic [ID_W-1:0]         r_hop;

    logic                    accept;
    logic                    nbr;
    logic [DIST_W:0]         sum_raw;
    logic [DIST_W-1:0]       sum_cap;
    logic                    rd_en;
    logic [$bits(t_entry)-1:0] ram_q;
    t_entry                  rd_entry;
    logic                    match;
    logic                    wr_en;
    logic [IW-1:0]           wr_idx;
    t_entry                  wr_entry;
    logic [STATUS_W-1:0]     fin_status;
    logic [ID_W-1:0]         fin_hop;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    assign nbr = ({{(32-ID_W){1'b0}}, i_sender_id} < 32'(ROUTER_IDS)) && r_mask[i_sender_id];

    assign sum_raw = {1'b0, i_advertised_distance} + {{(DIST_W+1-COST_W){1'b0}}, r_cost};
    assign sum_cap = (sum_raw > {1'b0, UNREACHABLE}) ? UNREACHABLE : sum_raw[DIST_W-1:0];

    assign rd_en    = (r_state == S_SCAN) && !r_issue_done;
    assign rd_entry = r_valid[r_cmp_idx] ? t_entry'(ram_q) : '0;
    assign match    = (rd_entry.net == r_net);

    always_comb begin
        wr_en      = 1'b0;
        wr_idx     = r_hit_idx;
        fin_hop    = '0;
        fin_status = ST_FULL;
        if (r_mode == MODE_UPDATE) begin
            if (!r_nbr) begin
                fin_status = ST_NOT_NEIGHBOR;
            end else if (r_net == '0) begin
                fin_status = ST_FULL;
            end else if (r_hit) begin
                fin_status = ST_UPDATED;
                wr_en      = (r_state == S_FIN);
            end else if (r_free) begin
                fin_status = ST_INSERTED;
                wr_idx     = r_free_idx;
                wr_en      = (r_state == S_FIN);
            end
        end else begin
            if (r_hit) begin
                fin_status = ST_FOUND;
                fin_hop    = r_best_hop;
            end else begin
                fin_status = ST_NOT_FOUND;
            end
        end
    end

    assign wr_entry.net    = r_net;
    assign wr_entry.hop    = r_sender;
    assign wr_entry.metric = r_sum;

    dvrt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mask       <= '0;
            r_cost       <= COST_RST;
            r_valid      <= '0;
            r_strobe     <= 1'b0;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_free       <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_NEIGHBOR_MASK: r_mask <= i_cfg_data;
                    REG_LINK_COST:     r_cost <= i_cfg_data[COST_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode       <= i_mode;
                        r_sender     <= i_sender_id;
                        r_net        <= i_dest_network;
                        r_sum        <= sum_cap;
                        r_nbr        <= nbr;
                        r_addr       <= '0;
                        r_issue_done <= 1'b0;
                        r_cmp_vld    <= 1'b0;
                        r_hit        <= 1'b0;
                        r_free       <= 1'b0;
                        if ((i_dest_network == '0) || ((i_mode == MODE_UPDATE) && !nbr)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= rd_en;
                    if (rd_en) begin
                        r_cmp_idx <= r_addr;
                        if (r_addr == LAST_IDX) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (r_cmp_vld) begin
                        if (r_mode == MODE_UPDATE) begin
                            if (match && !r_hit) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_cmp_idx;
                            end
                            if ((rd_entry.net == '0) && !r_free) begin
                                r_free     <= 1'b1;
                                r_free_idx <= r_cmp_idx;
                            end
                        end else if (match && (!r_hit || (rd_entry.metric < r_best))) begin
                            r_hit      <= 1'b1;
                            r_best     <= rd_entry.metric;
                            r_best_hop <= rd_entry.hop;
                        end
                        if (r_cmp_idx == LAST_IDX) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_strobe <= 1'b1;
                    r_status <= fin_status;
                    r_hop    <= fin_hop;
                    if (wr_en) begin
                        r_valid[wr_idx] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_next_hop = r_hop;

endmodule

FILE: hw/rtl/dvrt_chk.sv
// Port checker for the route table core, bound to the top level
`include "distance_vector_route_table_core_macros.svh"

module dvrt_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_strobe,
    input logic [dvrt_pkg::STATUS_W-1:0]     o_status,
    input logic [dvrt_pkg::ID_W-1:0]         o_next_hop
);

    import dvrt_pkg::*;

    // an accepted item keeps the block busy in the next cycle
    `DVRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !o_strobe)
    // a result strobe lasts one cycle
    `DVRT_ASSERT_NEXT(a_strobe_pulse, o_strobe, !o_strobe)
    // only found queries carry a next hop
    `DVRT_ASSERT_NOW(a_hop_zero, o_strobe && (o_status != ST_FOUND), o_next_hop == '0)
    // status is a defined code
    `DVRT_ASSERT_NOW(a_status_code, o_strobe, (o_status == ST_UPDATED) || (o_status == ST_INSERTED) || (o_status == ST_NOT_NEIGHBOR) || (o_status == ST_FULL) || (o_status == ST_FOUND) || (o_status == ST_NOT_FOUND))

endmodule

bind distance_vector_route_table_core dvrt_chk u_dvrt_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_status   (o_status),
    .o_next_hop (o_next_hop)
);
